// ----- rtl/ptcc_pkg.sv -----
package ptcc_pkg;

    // Configuration register indexes on the write port.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BCD_MODE    = 1'b1;
    localparam int CFG_DATA_W = 4;

    // Item function codes.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Counter widths.
    localparam int SUB_W     = 31;
    localparam int ELAPSED_W = 64;
    localparam int PERIOD_W  = 28;

    localparam logic [SUB_W-1:0] NS_PER_SEC = 31'd1000000000;

    // Reset values of the configuration registers.
    localparam logic [3:0] RATE_RESET = 4'd7;
    localparam logic       BCD_RESET  = 1'b1;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [3:0] rate_select;
        logic       bcd_mode;
    } cfg_t;

    // Calendar state; the year is kept as century and year within century.
    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] century;
        logic [6:0] yy;
    } cal_t;

    // 1970-01-01 00:00:00.
    localparam cal_t CAL_RESET = '{
        second:  6'd0,
        minute:  6'd0,
        hour:    5'd0,
        day:     5'd1,
        month:   4'd1,
        century: 7'd19,
        yy:      7'd70
    };

    // Tick period in nanoseconds; some rates alternate between two values.
    function automatic logic [PERIOD_W-1:0] period_ns(input logic [3:0] rate,
                                                      input logic phase);
        logic [PERIOD_W-1:0] p;
        begin
            case (rate)
                4'd0:    p = 28'd250000000;
                4'd1:    p = 28'd125000000;
                4'd2:    p = 28'd62500000;
                4'd3:    p = 28'd31250000;
                4'd4:    p = 28'd15625000;
                4'd5:    p = 28'd7812500;
                4'd6:    p = 28'd3906250;
                4'd7:    p = 28'd1953125;
                4'd8:    p = phase ? 28'd976563 : 28'd976562;
                4'd9:    p = 28'd488281;
                4'd10:   p = phase ? 28'd244141 : 28'd244140;
                default: p = 28'd122070;
            endcase
            return p;
        end
    endfunction

    // Days in a month of a common year.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        begin
            case (month)
                4'd2:    len = 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Month offset of the weekday formula.
    function automatic logic [2:0] month_code(input logic [3:0] month);
        logic [2:0] code;
        begin
            case (month)
                4'd2:    code = 3'd3;
                4'd3:    code = 3'd3;
                4'd4:    code = 3'd6;
                4'd5:    code = 3'd1;
                4'd6:    code = 3'd4;
                4'd7:    code = 3'd6;
                4'd8:    code = 3'd2;
                4'd9:    code = 3'd5;
                4'd11:   code = 3'd3;
                4'd12:   code = 3'd5;
                default: code = 3'd0;
            endcase
            return code;
        end
    endfunction

    // Remainder by 7 of an 8-bit value: reciprocal estimate, then one correction.
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [13:0] prod;
        logic [5:0]  q;
        logic [7:0]  r;
        begin
            prod = 14'(x) * 14'd36;
            q    = prod[13:8];
            r    = x - (8'(q) * 8'd7);
            if (r >= 8'd7)
            begin
                r = r - 8'd7;
            end
            return r[2:0];
        end
    endfunction

endpackage

// ----- rtl/ptcc_load_decode.sv -----
module ptcc_load_decode (
    input  ptcc_pkg::cfg_t cfg,
    input  logic [7:0]     load_second,
    input  logic [7:0]     load_minute,
    input  logic [7:0]     load_hour,
    input  logic [7:0]     load_day,
    input  logic [7:0]     load_month,
    input  logic [7:0]     load_year_low,
    input  logic [7:0]     load_century,
    output ptcc_pkg::cal_t load_cal
);

    // Optional BCD decode; nibbles above nine are taken at face value.
    function automatic logic [7:0] decode(input logic [7:0] b, input logic bcd);
        begin
            if (bcd)
            begin
                return ({4'd0, b[7:4]} << 3) + ({4'd0, b[7:4]} << 1) + {4'd0, b[3:0]};
            end
            return b;
        end
    endfunction

    logic [7:0] sec_d;
    logic [7:0] min_d;
    logic [7:0] hour_d;
    logic [7:0] day_d;
    logic [7:0] month_d;
    logic [7:0] yl_d;
    logic [7:0] cen_d;
    logic [1:0] yl_hundreds;
    logic [7:0] yl_rem;
    logic [8:0] cen_sum;

    always_comb
    begin
        sec_d   = decode(load_second, cfg.bcd_mode);
        min_d   = decode(load_minute, cfg.bcd_mode);
        hour_d  = decode(load_hour, cfg.bcd_mode);
        day_d   = decode(load_day, cfg.bcd_mode);
        month_d = decode(load_month, cfg.bcd_mode);
        yl_d    = decode(load_year_low, cfg.bcd_mode);
        cen_d   = decode(load_century, cfg.bcd_mode);

        // Time fields saturate at their maximum.
        load_cal.second = (sec_d > 8'd59) ? 6'd59 : sec_d[5:0];
        load_cal.minute = (min_d > 8'd59) ? 6'd59 : min_d[5:0];
        load_cal.hour   = (hour_d > 8'd23) ? 5'd23 : hour_d[4:0];

        // Day and month never go below one.
        if (day_d == 8'd0)
        begin
            load_cal.day = 5'd1;
        end
        else if (day_d > 8'd31)
        begin
            load_cal.day = 5'd31;
        end
        else
        begin
            load_cal.day = day_d[4:0];
        end

        if (month_d == 8'd0)
        begin
            load_cal.month = 4'd1;
        end
        else if (month_d > 8'd12)
        begin
            load_cal.month = 4'd12;
        end
        else
        begin
            load_cal.month = month_d[3:0];
        end

        // Fold hundreds of the year byte into the century, then saturate at 9999.
        if (yl_d >= 8'd200)
        begin
            yl_hundreds = 2'd2;
            yl_rem      = yl_d - 8'd200;
        end
        else if (yl_d >= 8'd100)
        begin
            yl_hundreds = 2'd1;
            yl_rem      = yl_d - 8'd100;
        end
        else
        begin
            yl_hundreds = 2'd0;
            yl_rem      = yl_d;
        end
        cen_sum = {1'b0, cen_d} + {7'd0, yl_hundreds};
        if (cen_sum > 9'd99)
        begin
            load_cal.century = 7'd99;
            load_cal.yy      = 7'd99;
        end
        else
        begin
            load_cal.century = cen_sum[6:0];
            load_cal.yy      = yl_rem[6:0];
        end
    end

endmodule

// ----- rtl/ptcc_time_core.sv -----
module ptcc_time_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             take,
    input  logic                             func,
    input  ptcc_pkg::cfg_t                   cfg,
    input  ptcc_pkg::cal_t                   load_cal,
    output ptcc_pkg::cal_t                   cal,
    output logic [ptcc_pkg::SUB_W-1:0]       subsecond,
    output logic [ptcc_pkg::ELAPSED_W-1:0]   elapsed,
    output logic                             tick_phase
);

    ptcc_pkg::cal_t                     cal_reg;
    ptcc_pkg::cal_t                     cal_next;
    ptcc_pkg::cal_t                     tick_cal;
    logic [ptcc_pkg::SUB_W-1:0]         sub_reg;
    logic [ptcc_pkg::SUB_W-1:0]         sub_next;
    logic [ptcc_pkg::ELAPSED_W-1:0]     elapsed_reg;
    logic [ptcc_pkg::ELAPSED_W-1:0]     elapsed_next;
    logic                               phase_reg;
    logic                               phase_next;
    logic [ptcc_pkg::PERIOD_W-1:0]      delta;
    logic [ptcc_pkg::SUB_W-1:0]         sub_sum;
    logic                               sec_wrap;
    logic                               leap;
    logic [4:0]                         len;
    logic                               last_day;

    // Sub-second accumulation and one-second carry.
    always_comb
    begin
        delta    = ptcc_pkg::period_ns(cfg.rate_select, phase_reg);
        sub_sum  = sub_reg + ptcc_pkg::SUB_W'(delta);
        sec_wrap = (sub_sum >= ptcc_pkg::NS_PER_SEC);
    end

    // Calendar advance on a whole second.
    always_comb
    begin
        leap     = (cal_reg.yy[1:0] == 2'd0) &&
                   ((cal_reg.yy != 7'd0) || (cal_reg.century[1:0] == 2'd0));
        len      = ptcc_pkg::month_len(cal_reg.month);
        last_day = ((cal_reg.day >= len) && !((cal_reg.month == 4'd2) && leap)) ||
                   (cal_reg.day > len);

        tick_cal = cal_reg;
        if (sec_wrap)
        begin
            if (cal_reg.second >= 6'd59)
            begin
                tick_cal.second = 6'd0;
                if (cal_reg.minute >= 6'd59)
                begin
                    tick_cal.minute = 6'd0;
                    if (cal_reg.hour >= 5'd23)
                    begin
                        tick_cal.hour = 5'd0;
                        if (last_day)
                        begin
                            tick_cal.day = 5'd1;
                            if (cal_reg.month >= 4'd12)
                            begin
                                tick_cal.month = 4'd1;
                                if (cal_reg.yy >= 7'd99)
                                begin
                                    tick_cal.yy = 7'd0;
                                    tick_cal.century = (cal_reg.century >= 7'd99) ?
                                                       7'd0 : cal_reg.century + 7'd1;
                                end
                                else
                                begin
                                    tick_cal.yy = cal_reg.yy + 7'd1;
                                end
                            end
                            else
                            begin
                                tick_cal.month = cal_reg.month + 4'd1;
                            end
                        end
                        else
                        begin
                            tick_cal.day = cal_reg.day + 5'd1;
                        end
                    end
                    else
                    begin
                        tick_cal.hour = cal_reg.hour + 5'd1;
                    end
                end
                else
                begin
                    tick_cal.minute = cal_reg.minute + 6'd1;
                end
            end
            else
            begin
                tick_cal.second = cal_reg.second + 6'd1;
            end
        end
    end

    // Next state for a tick or a load transfer.
    always_comb
    begin
        cal_next     = cal_reg;
        sub_next     = sub_reg;
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        if (take)
        begin
            if (func == ptcc_pkg::FUNC_LOAD)
            begin
                cal_next = load_cal;
            end
            else
            begin
                cal_next     = tick_cal;
                sub_next     = sec_wrap ? sub_sum - ptcc_pkg::NS_PER_SEC : sub_sum;
                elapsed_next = elapsed_reg + ptcc_pkg::ELAPSED_W'(delta);
                phase_next   = ~phase_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg     <= ptcc_pkg::CAL_RESET;
            sub_reg     <= '0;
            elapsed_reg <= '0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            cal_reg     <= cal_next;
            sub_reg     <= sub_next;
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
        end
    end

    assign cal        = cal_reg;
    assign subsecond  = sub_reg;
    assign elapsed    = elapsed_reg;
    assign tick_phase = phase_reg;

endmodule

// ----- rtl/ptcc_out_stage.sv -----
module ptcc_out_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             snap_valid,
    input  logic                             out_stall,
    input  ptcc_pkg::cal_t                   cal,
    input  logic [ptcc_pkg::SUB_W-1:0]       subsecond,
    input  logic [ptcc_pkg::ELAPSED_W-1:0]   elapsed,
    output logic                             capture,
    output logic                             out_valid,
    output logic [5:0]                       second_now,
    output logic [5:0]                       minute_now,
    output logic [4:0]                       hour_now,
    output logic [4:0]                       day_now,
    output logic [3:0]                       month_now,
    output logic [13:0]                      year_now,
    output logic [2:0]                       weekday_now,
    output logic [ptcc_pkg::SUB_W-1:0]       subsecond_ns,
    output logic [ptcc_pkg::ELAPSED_W-1:0]   elapsed_ns
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  wd_sum;
    logic [2:0]  weekday;
    logic [13:0] year_full;
    logic [13:0] cen_ext;

    // Weekday sum; every term is reduced together by one mod-7 step.
    always_comb
    begin
        wd_sum = 8'(cal.day) + 8'(ptcc_pkg::month_code(cal.month)) + 8'(cal.yy) +
                 8'(cal.yy[6:2]) + 8'({(2'd3 - cal.century[1:0]), 1'b0}) + 8'd7 -
                 8'(cal.month < 4'd3);
        weekday = ptcc_pkg::mod7(wd_sum);
    end

    // Full year as century times 100 plus year within century.
    always_comb
    begin
        cen_ext   = 14'(cal.century);
        year_full = (cen_ext << 6) + (cen_ext << 5) + (cen_ext << 2) + 14'(cal.yy);
    end

    // The result register takes the state snapshot whenever it is empty or draining.
    always_comb
    begin
        capture        = snap_valid && (!out_valid_reg || !out_stall);
        out_valid_next = capture || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            second_now   <= cal.second;
            minute_now   <= cal.minute;
            hour_now     <= cal.hour;
            day_now      <= cal.day;
            month_now    <= cal.month;
            year_now     <= year_full;
            weekday_now  <= weekday;
            subsecond_ns <= subsecond;
            elapsed_ns   <= elapsed;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/periodic_tick_calendar_clock.sv -----
// Channel   Direction  Handshake            Payload
// input     in         in_valid, in_stall   func, load_second .. load_century
// result    out        out_valid, out_stall second_now .. elapsed_ns
// config    in         cfg_we               cfg_index, cfg_data
//
// One item is taken per clock while in_stall is low; each result passes the state
// registers and then the result register before it reaches the output to be taken.
// The rate is set by the state update: period lookup, sub-second add and
// one-second compare, then the calendar carry chain, all ahead of the state registers.
// Reset gives rate 7, BCD loading, and 1970-01-01 00:00:00 with zero counters.
// in_stall rises only while a finished result waits stalled at the output
// and the state stage already holds the next one.
module periodic_tick_calendar_clock (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ptcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic [7:0]                         load_second,
    input  logic [7:0]                         load_minute,
    input  logic [7:0]                         load_hour,
    input  logic [7:0]                         load_day,
    input  logic [7:0]                         load_month,
    input  logic [7:0]                         load_year_low,
    input  logic [7:0]                         load_century,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [5:0]                         second_now,
    output logic [5:0]                         minute_now,
    output logic [4:0]                         hour_now,
    output logic [4:0]                         day_now,
    output logic [3:0]                         month_now,
    output logic [13:0]                        year_now,
    output logic [2:0]                         weekday_now,
    output logic [ptcc_pkg::SUB_W-1:0]         subsecond_ns,
    output logic [ptcc_pkg::ELAPSED_W-1:0]     elapsed_ns
);

    ptcc_pkg::cfg_t                     cfg_reg;
    ptcc_pkg::cfg_t                     cfg_next;
    ptcc_pkg::cal_t                     load_cal;
    ptcc_pkg::cal_t                     cal;
    logic [ptcc_pkg::SUB_W-1:0]         subsecond;
    logic [ptcc_pkg::ELAPSED_W-1:0]     elapsed;
    logic                               tick_phase;
    logic                               snap_valid_reg;
    logic                               snap_valid_next;
    logic                               capture;
    logic                               in_take;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ptcc_pkg::CFG_RATE_SELECT: cfg_next.rate_select = cfg_data[3:0];
                ptcc_pkg::CFG_BCD_MODE:    cfg_next.bcd_mode    = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_select <= ptcc_pkg::RATE_RESET;
            cfg_reg.bcd_mode    <= ptcc_pkg::BCD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input transfer control: the state stage holds one unreported result.
    always_comb
    begin
        in_stall        = snap_valid_reg && !capture;
        in_take         = in_valid && !in_stall;
        snap_valid_next = in_take || (snap_valid_reg && !capture);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
        end
    end

    ptcc_load_decode u_load_decode (
        .cfg           (cfg_reg),
        .load_second   (load_second),
        .load_minute   (load_minute),
        .load_hour     (load_hour),
        .load_day      (load_day),
        .load_month    (load_month),
        .load_year_low (load_year_low),
        .load_century  (load_century),
        .load_cal      (load_cal)
    );

    ptcc_time_core u_time_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (in_take),
        .func       (func),
        .cfg        (cfg_reg),
        .load_cal   (load_cal),
        .cal        (cal),
        .subsecond  (subsecond),
        .elapsed    (elapsed),
        .tick_phase (tick_phase)
    );

    ptcc_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_valid   (snap_valid_reg),
        .out_stall    (out_stall),
        .cal          (cal),
        .subsecond    (subsecond),
        .elapsed      (elapsed),
        .capture      (capture),
        .out_valid    (out_valid),
        .second_now   (second_now),
        .minute_now   (minute_now),
        .hour_now     (hour_now),
        .day_now      (day_now),
        .month_now    (month_now),
        .year_now     (year_now),
        .weekday_now  (weekday_now),
        .subsecond_ns (subsecond_ns),
        .elapsed_ns   (elapsed_ns)
    );

    // A load leaves the counters and the tick phase alone.
    a_load_keeps_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && func == ptcc_pkg::FUNC_LOAD) |=>
        ($stable(subsecond) && $stable(elapsed) && $stable(tick_phase)))
        else $error("load transfer changed the tick counters");

    // The elapsed count moves only on a tick transfer.
    a_elapsed_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_take && func == ptcc_pkg::FUNC_TICK) |=> $stable(elapsed))
        else $error("elapsed count changed without a tick");

    // Every tick flips the period phase.
    a_tick_flips_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && func == ptcc_pkg::FUNC_TICK) |=> (tick_phase != $past(tick_phase)))
        else $error("tick did not toggle the period phase");

    // Calendar and sub-second state stay in range.
    a_state_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (subsecond < ptcc_pkg::NS_PER_SEC) && (cal.second < 6'd60) &&
        (cal.minute < 6'd60) && (cal.hour < 5'd24) && (cal.day != 5'd0) &&
        (cal.month != 4'd0) && (cal.month < 4'd13) && (cal.century < 7'd100) &&
        (cal.yy < 7'd100))
        else $error("clock state out of range");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int ITEMS_PER_PHASE = 94;
    localparam int SETTLE_CYCLES   = 4;
    localparam int LONG_HOLD       = 80;

    // Rate used in each random phase; the BCD flag alternates with the phase.
    localparam bit [7:0][3:0] PHASE_RATE = {4'd0, 4'd12, 4'd1, 4'd10,
                                            4'd15, 4'd8, 4'd11, 4'd0};

    // Month offsets of the weekday formula, January in the lowest slot.
    localparam bit [11:0][2:0] MONTH_OFFSET = {3'd5, 3'd3, 3'd0, 3'd5, 3'd2, 3'd6,
                                               3'd4, 3'd1, 3'd6, 3'd3, 3'd3, 3'd0};

    // One reading of the clock as it appears on the result port.
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [2:0]  wday;
        logic [30:0] sub_ns;
        logic [63:0] total_ns;
    } clock_reading_t;

    typedef enum logic [1:0] {ROW_TICK, ROW_LOAD, ROW_SET_RATE, ROW_SET_BCD} row_kind_t;

    typedef enum {RX_FLOW, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} rx_pattern_t;

    // Load bytes are packed century, year, month, day, hour, minute, second
    // from the top down, so index 0 is the seconds byte.
    typedef struct packed {
        row_kind_t       kind;
        bit [6:0][7:0]   raw;
        bit [3:0]        reg_value;
        bit              typed_ok;
        clock_reading_t  typed;
    } stim_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [ptcc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [ptcc_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                func = ptcc_pkg::FUNC_TICK;
    logic [7:0]                          load_second = '0;
    logic [7:0]                          load_minute = '0;
    logic [7:0]                          load_hour = '0;
    logic [7:0]                          load_day = '0;
    logic [7:0]                          load_month = '0;
    logic [7:0]                          load_year_low = '0;
    logic [7:0]                          load_century = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [5:0]                          second_now;
    logic [5:0]                          minute_now;
    logic [4:0]                          hour_now;
    logic [4:0]                          day_now;
    logic [3:0]                          month_now;
    logic [13:0]                         year_now;
    logic [2:0]                          weekday_now;
    logic [ptcc_pkg::SUB_W-1:0]          subsecond_ns;
    logic [ptcc_pkg::ELAPSED_W-1:0]      elapsed_ns;

    periodic_tick_calendar_clock dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .load_second   (load_second),
        .load_minute   (load_minute),
        .load_hour     (load_hour),
        .load_day      (load_day),
        .load_month    (load_month),
        .load_year_low (load_year_low),
        .load_century  (load_century),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .second_now    (second_now),
        .minute_now    (minute_now),
        .hour_now      (hour_now),
        .day_now       (day_now),
        .month_now     (month_now),
        .year_now      (year_now),
        .weekday_now   (weekday_now),
        .subsecond_ns  (subsecond_ns),
        .elapsed_ns    (elapsed_ns)
    );

    // Shadow of the configuration registers.
    bit [3:0]  cfg_rate = ptcc_pkg::RATE_RESET;
    bit        cfg_bcd = ptcc_pkg::BCD_RESET;

    // Predicted clock state.
    bit        cal_phase = 1'b0;
    bit [63:0] cal_total_ns = '0;
    bit [30:0] cal_sub_ns = '0;
    bit [5:0]  cal_second = '0;
    bit [5:0]  cal_minute = '0;
    bit [4:0]  cal_hour = '0;
    bit [4:0]  cal_day = 5'd1;
    bit [3:0]  cal_month = 4'd1;
    bit [13:0] cal_year = 14'd1970;

    clock_reading_t expected_readings[$];
    stim_row_t      directed_rows[$];
    int             fault_count = 0;
    bit             hold_request = 1'b0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Byte from the load port to a binary value, honoring the BCD flag.
    function automatic int raw_to_bin(bit [7:0] b);
        if (cfg_bcd)
            return int'(b[7:4]) * 10 + int'(b[3:0]);
        return int'(b);
    endfunction

    // Binary value to the byte a host would write in the current mode.
    function automatic bit [7:0] to_reg_byte(int v);
        if (cfg_bcd)
            return 8'(((v / 10) << 4) | (v % 10));
        return 8'(v);
    endfunction

    // Apply one tick or load to the predicted state and return the reading.
    function automatic clock_reading_t advance_calendar(logic f, bit [6:0][7:0] b);
        clock_reading_t r;
        int  rate;
        int  mlen;
        int  y;
        int  yy;
        int  cc;
        int  wsum;
        bit  leap;
        bit [27:0] step;
        if (f == ptcc_pkg::FUNC_LOAD)
        begin
            // Decoded fields saturate into their legal ranges.
            cal_second = 6'((raw_to_bin(b[0]) > 59) ? 59 : raw_to_bin(b[0]));
            cal_minute = 6'((raw_to_bin(b[1]) > 59) ? 59 : raw_to_bin(b[1]));
            cal_hour   = 5'((raw_to_bin(b[2]) > 23) ? 23 : raw_to_bin(b[2]));
            cal_day    = 5'((raw_to_bin(b[3]) < 1) ? 1 :
                            (raw_to_bin(b[3]) > 31) ? 31 : raw_to_bin(b[3]));
            cal_month  = 4'((raw_to_bin(b[4]) < 1) ? 1 :
                            (raw_to_bin(b[4]) > 12) ? 12 : raw_to_bin(b[4]));
            y = raw_to_bin(b[6]) * 100 + raw_to_bin(b[5]);
            cal_year   = 14'((y > 9999) ? 9999 : y);
        end
        else
        begin
            // Nominal period is 250 ms halved per rate step; the two rates
            // whose period falls near half a nanosecond alternate up by one.
            rate = (cfg_rate > 11) ? 11 : int'(cfg_rate);
            step = (28'd250000000 >> rate) + 28'(((rate == 8) || (rate == 10)) ? cal_phase : 1'b0);
            cal_phase = ~cal_phase;
            cal_total_ns = cal_total_ns + 64'(step);
            cal_sub_ns = cal_sub_ns + 31'(step);
            if (cal_sub_ns >= 31'd1000000000)
            begin
                cal_sub_ns = cal_sub_ns - 31'd1000000000;
                cal_second = cal_second + 6'd1;
                if (cal_second >= 6'd60)
                begin
                    cal_second = '0;
                    cal_minute = cal_minute + 6'd1;
                    if (cal_minute >= 6'd60)
                    begin
                        cal_minute = '0;
                        cal_hour = cal_hour + 5'd1;
                        if (cal_hour >= 5'd24)
                        begin
                            // Midnight: a day past the month length moves to the 1st.
                            cal_hour = '0;
                            leap = (cal_year % 4 == 0) &&
                                   ((cal_year % 100 != 0) || (cal_year % 400 == 0));
                            if (cal_month == 4'd2)
                                mlen = leap ? 29 : 28;
                            else if ((cal_month == 4'd4) || (cal_month == 4'd6) ||
                                     (cal_month == 4'd9) || (cal_month == 4'd11))
                                mlen = 30;
                            else
                                mlen = 31;
                            if (int'(cal_day) + 1 > mlen)
                            begin
                                cal_day = 5'd1;
                                if (cal_month == 4'd12)
                                begin
                                    cal_month = 4'd1;
                                    cal_year = (cal_year >= 14'd9999) ? 14'd0 : cal_year + 14'd1;
                                end
                                else
                                begin
                                    cal_month = cal_month + 4'd1;
                                end
                            end
                            else
                            begin
                                cal_day = cal_day + 5'd1;
                            end
                        end
                    end
                end
            end
        end

        // Weekday from the month-offset formula, kept non-negative before mod 7.
        yy = int'(cal_year) % 100;
        cc = int'(cal_year) / 100;
        wsum = int'(cal_day) % 7 + int'(MONTH_OFFSET[cal_month - 1]) + (yy + yy / 4) % 7
               + (3 - cc % 4) * 2 + 7 - ((cal_month < 4'd3) ? 1 : 0);

        r.second   = cal_second;
        r.minute   = cal_minute;
        r.hour     = cal_hour;
        r.day      = cal_day;
        r.month    = cal_month;
        r.year     = cal_year;
        r.wday     = 3'(wsum % 7);
        r.sub_ns   = cal_sub_ns;
        r.total_ns = cal_total_ns;
        return r;
    endfunction

    // Bytes for a random load: mostly a second before a month-end midnight.
    function automatic bit [6:0][7:0] random_load_bytes();
        int k;
        int s;
        int mi;
        int h;
        int d;
        int mo;
        int y;
        k = $urandom_range(0, 9);
        if (k == 9)
            return 56'({$urandom, $urandom});
        if (k < 6)
        begin
            s  = 59;
            mi = 59;
            h  = 23;
            d  = $urandom_range(27, 31);
        end
        else
        begin
            s  = $urandom_range(0, 59);
            mi = $urandom_range(0, 59);
            h  = $urandom_range(0, 23);
            d  = $urandom_range(1, 31);
        end
        mo = $urandom_range(1, 12);
        case ($urandom_range(0, 5))
            0: y = 1900;
            1: y = 2000;
            2: y = 2024;
            3: y = 2023;
            4: y = 9999;
            default: y = $urandom_range(0, 9999);
        endcase
        return {to_reg_byte(y / 100), to_reg_byte(y % 100), to_reg_byte(mo),
                to_reg_byte(d), to_reg_byte(h), to_reg_byte(mi), to_reg_byte(s)};
    endfunction

    function automatic stim_row_t row_of(row_kind_t k, bit [6:0][7:0] b, bit [3:0] v,
                                         bit typed_ok, clock_reading_t typed);
        stim_row_t row;
        row.kind      = k;
        row.raw       = b;
        row.reg_value = v;
        row.typed_ok  = typed_ok;
        row.typed     = typed;
        return row;
    endfunction

    // Wait until every expected reading has come back, then let the pipe settle.
    task automatic wait_drained();
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic sender_idle(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Register write; only done with the block drained.
    task automatic set_register(logic [ptcc_pkg::CFG_IDX_W-1:0] idx, bit [3:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == ptcc_pkg::CFG_RATE_SELECT)
            cfg_rate = v;
        else
            cfg_bcd = v[0];
    endtask

    // Offer one item, wait for its transfer, then record what it should produce.
    task automatic send_item(logic f, bit [6:0][7:0] b, bit typed_ok, clock_reading_t typed);
        clock_reading_t predicted;
        @(negedge clk);
        in_valid      <= 1'b1;
        func          <= f;
        load_second   <= b[0];
        load_minute   <= b[1];
        load_hour     <= b[2];
        load_day      <= b[3];
        load_month    <= b[4];
        load_year_low <= b[5];
        load_century  <= b[6];
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = advance_calendar(f, b);
        expected_readings.push_back(typed_ok ? typed : predicted);
    endtask

    task automatic field_check(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    // Result monitor: each transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin
        clock_reading_t want;
        if (rst_n && (out_valid === 1'b1) && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("result transfer with no reading expected");
                fault_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                field_check("second_now", 64'(want.second), 64'(second_now));
                field_check("minute_now", 64'(want.minute), 64'(minute_now));
                field_check("hour_now", 64'(want.hour), 64'(hour_now));
                field_check("day_now", 64'(want.day), 64'(day_now));
                field_check("month_now", 64'(want.month), 64'(month_now));
                field_check("year_now", 64'(want.year), 64'(year_now));
                field_check("weekday_now", 64'(want.wday), 64'(weekday_now));
                field_check("subsecond_ns", 64'(want.sub_ns), 64'(subsecond_ns));
                field_check("elapsed_ns", want.total_ns, elapsed_ns);
            end
        end
    end

    // Receiver: switches among stall patterns, with one long hold on request.
    initial
    begin
        rx_pattern_t pattern;
        int          pattern_left;
        int          hold_left;
        pattern = RX_FLOW;
        pattern_left = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern = rx_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(10, 60);
                end
                pattern_left--;
                case (pattern)
                    RX_FLOW:        out_stall <= 1'b0;
                    RX_COIN:        out_stall <= 1'($urandom_range(0, 1));
                    RX_EVERY_THIRD: out_stall <= (pattern_left % 3 == 0);
                    default:        out_stall <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Stimulus: directed table, then random phases over several settings.
    initial
    begin
        bit [6:0][7:0] b;
        logic          f;
        int            burst_left;
        stim_row_t     row;

        // Right after reset: 1970-01-01 at the default rate.
        directed_rows.push_back(row_of(ROW_TICK, '0, 4'd0, 1'b1,
            {6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 14'd1970, 3'd3, 31'd1953125, 64'd1953125}));
        // All-ones BCD load saturates every field; counters are untouched.
        directed_rows.push_back(row_of(ROW_LOAD, {7{8'hFF}}, 4'd0, 1'b1,
            {6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 14'd9999, 3'd5, 31'd1953125, 64'd1953125}));
        // All-zero load: day and month are raised to 1, year 0.
        directed_rows.push_back(row_of(ROW_LOAD, '0, 4'd0, 1'b1,
            {6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 14'd0, 3'd6, 31'd1953125, 64'd1953125}));
        directed_rows.push_back(row_of(ROW_SET_RATE, '0, 4'd0, 1'b0, '0));
        // Last second of year 9999 wraps to year 0.
        directed_rows.push_back(row_of(ROW_LOAD,
            {8'h99, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59}, 4'd0, 1'b0, '0));
        repeat (4) directed_rows.push_back(row_of(ROW_TICK, '0, 4'd0, 1'b0, '0));
        // Leap day of a century leap year.
        directed_rows.push_back(row_of(ROW_LOAD,
            {8'h20, 8'h00, 8'h02, 8'h28, 8'h23, 8'h59, 8'h59}, 4'd0, 1'b0, '0));
        repeat (4) directed_rows.push_back(row_of(ROW_TICK, '0, 4'd0, 1'b0, '0));
        // A day beyond the month length holds until midnight.
        directed_rows.push_back(row_of(ROW_LOAD,
            {8'h20, 8'h23, 8'h02, 8'h31, 8'h23, 8'h59, 8'h59}, 4'd0, 1'b0, '0));
        repeat (4) directed_rows.push_back(row_of(ROW_TICK, '0, 4'd0, 1'b0, '0));
        // Binary loading and a rate index above the table, then a saturating load.
        directed_rows.push_back(row_of(ROW_SET_BCD, '0, 4'd0, 1'b0, '0));
        directed_rows.push_back(row_of(ROW_SET_RATE, '0, 4'd15, 1'b0, '0));
        directed_rows.push_back(row_of(ROW_LOAD, {7{8'hFF}}, 4'd0, 1'b0, '0));
        repeat (2) directed_rows.push_back(row_of(ROW_TICK, '0, 4'd0, 1'b0, '0));
        // Alternating periods; the phase carries over the rate change.
        directed_rows.push_back(row_of(ROW_SET_RATE, '0, 4'd8, 1'b0, '0));
        repeat (3) directed_rows.push_back(row_of(ROW_TICK, '0, 4'd0, 1'b0, '0));
        directed_rows.push_back(row_of(ROW_SET_RATE, '0, 4'd11, 1'b0, '0));
        directed_rows.push_back(row_of(ROW_TICK, '0, 4'd0, 1'b0, '0));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            case (row.kind)
                ROW_TICK:     send_item(ptcc_pkg::FUNC_TICK, row.raw, row.typed_ok, row.typed);
                ROW_LOAD:     send_item(ptcc_pkg::FUNC_LOAD, row.raw, row.typed_ok, row.typed);
                ROW_SET_RATE: set_register(ptcc_pkg::CFG_RATE_SELECT, row.reg_value);
                default:      set_register(ptcc_pkg::CFG_BCD_MODE, row.reg_value);
            endcase
        end

        // Random phases: bursts of ticks with loads mixed in.
        for (int p = 0; p < 8; p++)
        begin
            set_register(ptcc_pkg::CFG_RATE_SELECT, PHASE_RATE[p]);
            set_register(ptcc_pkg::CFG_BCD_MODE, {3'($urandom), ~p[0]});
            burst_left = 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ((p == 2) && (i == 20))
                begin
                    // Long receiver hold while the sender keeps offering.
                    hold_request = 1'b1;
                    burst_left = 2 * LONG_HOLD;
                end
                if ((p == 5) && (i == 40))
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    wait_drained();
                end
                if (burst_left == 0)
                begin
                    sender_idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                if ($urandom_range(0, 99) < 15)
                begin
                    f = ptcc_pkg::FUNC_LOAD;
                    b = random_load_bytes();
                end
                else
                begin
                    f = ptcc_pkg::FUNC_TICK;
                    b = 56'({$urandom, $urandom});
                end
                send_item(f, b, 1'b0, '0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
